// ===== src/wrsn_pkg.sv =====
// Shared types, constants and helpers for the WPA/RSN element parser.
// No dependencies; used by wrsn_parse, wrsn_out and wpa_rsn_element_parser.
package wrsn_pkg;

    // element ids
    localparam logic [7:0] ID_RSN    = 8'h30;
    localparam logic [7:0] ID_VENDOR = 8'hdd;
    localparam logic [7:0] WPA_TYPE  = 8'h01;

    // OUI bytes
    localparam logic [7:0] OUI_B0     = 8'h00;
    localparam logic [7:0] WPA_OUI_B1 = 8'h50;
    localparam logic [7:0] WPA_OUI_B2 = 8'hf2;
    localparam logic [7:0] RSN_OUI_B1 = 8'h0f;
    localparam logic [7:0] RSN_OUI_B2 = 8'hac;

    // parse stage codes
    localparam logic [3:0] ST_HEADER = 4'd0;
    localparam logic [3:0] ST_VOUI   = 4'd1;
    localparam logic [3:0] ST_VER    = 4'd2;
    localparam logic [3:0] ST_GROUP  = 4'd3;
    localparam logic [3:0] ST_PCNT   = 4'd4;
    localparam logic [3:0] ST_PLIST  = 4'd5;
    localparam logic [3:0] ST_ACNT   = 4'd6;
    localparam logic [3:0] ST_ALIST  = 4'd7;
    localparam logic [3:0] ST_CAPS   = 4'd8;
    localparam logic [3:0] ST_DONE   = 4'd9;
    localparam logic [3:0] ST_REJECT = 4'd15;

    localparam logic [8:0] POS_MAX = 9'd511;

    // result codes
    localparam logic [1:0] KIND_OTHER   = 2'd0;
    localparam logic [1:0] KIND_BAD     = 2'd1;
    localparam logic [1:0] KIND_WPA     = 2'd2;
    localparam logic [1:0] KIND_RSN     = 2'd3;

    localparam logic [1:0] GRP_ABSENT   = 2'd0;
    localparam logic [1:0] GRP_DEFAULT  = 2'd1;
    localparam logic [1:0] GRP_PROPR    = 2'd2;
    localparam logic [1:0] GRP_STD      = 2'd3;

    localparam logic [1:0] PW_NONE      = 2'd0;
    localparam logic [1:0] PW_DEFAULT   = 2'd1;
    localparam logic [1:0] PW_TRUNC     = 2'd2;
    localparam logic [1:0] PW_COMPLETE  = 2'd3;

    localparam logic [1:0] AKM_ABSENT   = 2'd0;
    localparam logic [1:0] AKM_TRUNC    = 2'd1;
    localparam logic [1:0] AKM_COMPLETE = 2'd2;

    // parser state after the current byte, as seen by the result stage
    typedef struct packed {
        logic [7:0]  elem_id;
        logic [3:0]  stage;
        logic [15:0] version;
        logic [7:0]  grp_type;
        logic        grp_prop;
        logic [15:0] pw_count;
        logic [7:0]  pw_mask;
        logic [15:0] akm_count;
        logic [4:0]  akm_mask;
        logic        cap_bit0;
    } t_parse_view;

    // expected OUI byte of a cipher/AKM suite
    function automatic logic [7:0] suite_oui(input logic is_rsn, input logic [1:0] idx);
        logic [7:0] r;
        unique case (idx)
            2'd0:    r = OUI_B0;
            2'd1:    r = is_rsn ? RSN_OUI_B1 : WPA_OUI_B1;
            2'd2:    r = is_rsn ? RSN_OUI_B2 : WPA_OUI_B2;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

// ===== src/wrsn_parse.sv =====
// Byte-at-a-time parse state of the WPA/RSN element parser.
// Depends on wrsn_pkg; exposes the post-byte state to wrsn_out.
module wrsn_parse (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic [7:0]            i_element_byte,
    input  logic                  i_last_byte,
    output wrsn_pkg::t_parse_view o_view
);

    logic [8:0]  r_pos, n_pos;
    logic [7:0]  r_id, n_id;
    logic [7:0]  r_len, n_len;
    logic [3:0]  r_stage, n_stage;
    logic [8:0]  r_fstart, n_fstart;
    logic        r_oui, n_oui;
    logic [7:0]  r_stype, n_stype;
    logic [15:0] r_remain, n_remain;
    logic [15:0] r_version, n_version;
    logic [7:0]  r_grp_type, n_grp_type;
    logic        r_grp_prop, n_grp_prop;
    logic [15:0] r_pw_count, n_pw_count;
    logic [7:0]  r_pw_mask, n_pw_mask;
    logic [15:0] r_akm_count, n_akm_count;
    logic [4:0]  r_akm_mask, n_akm_mask;
    logic        r_cap, n_cap;

    logic [8:0]  idx;
    logic [1:0]  sidx;
    logic [8:0]  pos_inc;
    logic        in_elem;
    logic [7:0]  exp_oui;
    logic        suite_done;
    logic [15:0] cnt_full;
    logic [15:0] rem_dec;
    logic [2:0]  mask_bit;
    logic [7:0]  b;

    always_comb begin
        b          = i_element_byte;
        idx        = r_pos - r_fstart;
        sidx       = idx[1:0];
        pos_inc    = r_pos + 9'd1;
        in_elem    = {1'b0, r_pos} < ({2'b00, r_len} + 10'd2);
        exp_oui    = wrsn_pkg::suite_oui(r_id == wrsn_pkg::ID_RSN, sidx);
        suite_done = (sidx == 2'd3);
        cnt_full   = r_remain | {b, 8'h00};
        rem_dec    = r_remain - 16'd1;
        mask_bit   = 3'd0;

        n_pos       = r_pos;
        n_id        = r_id;
        n_len       = r_len;
        n_stage     = r_stage;
        n_fstart    = r_fstart;
        n_oui       = r_oui;
        n_stype     = r_stype;
        n_remain    = r_remain;
        n_version   = r_version;
        n_grp_type  = r_grp_type;
        n_grp_prop  = r_grp_prop;
        n_pw_count  = r_pw_count;
        n_pw_mask   = r_pw_mask;
        n_akm_count = r_akm_count;
        n_akm_mask  = r_akm_mask;
        n_cap       = r_cap;

        // OUI tracking shared by all suite fields
        if (r_stage == wrsn_pkg::ST_GROUP || r_stage == wrsn_pkg::ST_PLIST ||
            r_stage == wrsn_pkg::ST_ALIST) begin
            if (sidx == 2'd0) begin
                n_oui = (b == exp_oui);
            end else if (!suite_done) begin
                n_oui = r_oui && (b == exp_oui);
            end else begin
                n_stype = b;
            end
        end

        if (r_pos == 9'd0) begin
            n_id = b;
        end else if (r_pos == 9'd1) begin
            n_len = b;
            if (r_id == wrsn_pkg::ID_VENDOR) begin
                n_stage  = wrsn_pkg::ST_VOUI;
                n_fstart = pos_inc;
            end else if (r_id == wrsn_pkg::ID_RSN) begin
                n_stage  = wrsn_pkg::ST_VER;
                n_fstart = pos_inc;
            end else begin
                n_stage = wrsn_pkg::ST_DONE;
            end
        end else if (in_elem) begin
            unique case (r_stage)
                wrsn_pkg::ST_VOUI: begin
                    if (idx < 9'd3) begin
                        n_oui = r_oui && (b == wrsn_pkg::suite_oui(1'b0, idx[1:0]));
                    end else if (r_oui && b == wrsn_pkg::WPA_TYPE) begin
                        n_stage  = wrsn_pkg::ST_VER;
                        n_fstart = pos_inc;
                    end else begin
                        n_stage = wrsn_pkg::ST_REJECT;
                    end
                end
                wrsn_pkg::ST_VER: begin
                    if (idx == 9'd0) begin
                        n_version = r_version | {8'h00, b};
                    end else begin
                        n_version = r_version | {b, 8'h00};
                        n_stage   = wrsn_pkg::ST_GROUP;
                        n_fstart  = pos_inc;
                    end
                end
                wrsn_pkg::ST_GROUP: begin
                    if (suite_done) begin
                        if (r_oui) begin
                            n_grp_type = r_grp_type | b;
                        end else begin
                            n_grp_prop = 1'b1;
                        end
                        n_stage  = wrsn_pkg::ST_PCNT;
                        n_fstart = pos_inc;
                    end
                end
                wrsn_pkg::ST_PCNT, wrsn_pkg::ST_ACNT: begin
                    if (idx == 9'd0) begin
                        n_remain = {8'h00, b};
                    end else begin
                        n_remain = cnt_full;
                        n_fstart = pos_inc;
                        if (r_stage == wrsn_pkg::ST_PCNT) begin
                            n_pw_count = r_pw_count | cnt_full;
                            n_stage    = (cnt_full == 16'd0) ? wrsn_pkg::ST_ACNT
                                                             : wrsn_pkg::ST_PLIST;
                        end else begin
                            n_akm_count = r_akm_count | cnt_full;
                            n_stage     = (cnt_full == 16'd0) ? wrsn_pkg::ST_CAPS
                                                              : wrsn_pkg::ST_ALIST;
                        end
                    end
                end
                wrsn_pkg::ST_PLIST, wrsn_pkg::ST_ALIST: begin
                    if (suite_done) begin
                        if (r_stage == wrsn_pkg::ST_PLIST) begin
                            if (!r_oui)        mask_bit = 3'd7;
                            else if (b < 8'd6) mask_bit = b[2:0];
                            else               mask_bit = 3'd6;
                            n_pw_mask = r_pw_mask | (8'd1 << mask_bit);
                        end else begin
                            if (!r_oui)        mask_bit = 3'd4;
                            else if (b < 8'd3) mask_bit = b[2:0];
                            else               mask_bit = 3'd3;
                            n_akm_mask = r_akm_mask | (5'd1 << mask_bit);
                        end
                        n_remain = rem_dec;
                        n_fstart = pos_inc;
                        if (rem_dec == 16'd0) begin
                            n_stage = (r_stage == wrsn_pkg::ST_PLIST) ? wrsn_pkg::ST_ACNT
                                                                      : wrsn_pkg::ST_CAPS;
                        end
                    end
                end
                wrsn_pkg::ST_CAPS: begin
                    n_cap   = r_cap | b[0];
                    n_stage = wrsn_pkg::ST_DONE;
                end
                default: begin
                end
            endcase
        end

        if (r_pos != wrsn_pkg::POS_MAX) begin
            n_pos = pos_inc;
        end
    end

    always_comb begin
        o_view.elem_id   = n_id;
        o_view.stage     = n_stage;
        o_view.version   = n_version;
        o_view.grp_type  = n_grp_type;
        o_view.grp_prop  = n_grp_prop;
        o_view.pw_count  = n_pw_count;
        o_view.pw_mask   = n_pw_mask;
        o_view.akm_count = n_akm_count;
        o_view.akm_mask  = n_akm_mask;
        o_view.cap_bit0  = n_cap;
    end

    // the element restarts after the buffer's last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_last_byte)) begin
            r_pos       <= '0;
            r_id        <= '0;
            r_len       <= '0;
            r_stage     <= wrsn_pkg::ST_HEADER;
            r_fstart    <= '0;
            r_oui       <= 1'b1;
            r_stype     <= '0;
            r_remain    <= '0;
            r_version   <= '0;
            r_grp_type  <= '0;
            r_grp_prop  <= 1'b0;
            r_pw_count  <= '0;
            r_pw_mask   <= '0;
            r_akm_count <= '0;
            r_akm_mask  <= '0;
            r_cap       <= 1'b0;
        end else if (i_accept) begin
            r_pos       <= n_pos;
            r_id        <= n_id;
            r_len       <= n_len;
            r_stage     <= n_stage;
            r_fstart    <= n_fstart;
            r_oui       <= n_oui;
            r_stype     <= n_stype;
            r_remain    <= n_remain;
            r_version   <= n_version;
            r_grp_type  <= n_grp_type;
            r_grp_prop  <= n_grp_prop;
            r_pw_count  <= n_pw_count;
            r_pw_mask   <= n_pw_mask;
            r_akm_count <= n_akm_count;
            r_akm_mask  <= n_akm_mask;
            r_cap       <= n_cap;
        end
    end

`ifndef SYNTHESIS
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_last_byte) |=> (r_pos == 9'd0 && r_stage == wrsn_pkg::ST_HEADER))
        else $error("parser did not restart after last byte");

    a_header_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_stage == wrsn_pkg::ST_HEADER) |-> (r_pos <= 9'd1))
        else $error("header stage past the length byte");

    a_pos_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && !i_last_byte && r_pos != wrsn_pkg::POS_MAX)
        |=> (r_pos == $past(r_pos) + 9'd1))
        else $error("byte position did not advance");

    a_pw_mask_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pw_mask != 8'd0) |-> (r_stage >= wrsn_pkg::ST_PLIST && r_stage <= wrsn_pkg::ST_DONE))
        else $error("pairwise mask set outside suite list");
`endif

endmodule

// ===== src/wrsn_out.sv =====
// Summary formatting and result register of the WPA/RSN element parser.
// Depends on wrsn_pkg; fed by wrsn_parse through t_parse_view.
module wrsn_out (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  wrsn_pkg::t_parse_view i_view,
    input  logic                  i_out_ready,
    output logic                  o_free,
    output logic                  o_out_valid,
    output logic [1:0]            o_element_kind,
    output logic [15:0]           o_version,
    output logic [1:0]            o_group_state,
    output logic [7:0]            o_group_cipher,
    output logic [1:0]            o_pairwise_state,
    output logic [15:0]           o_pairwise_count,
    output logic [7:0]            o_pairwise_mask,
    output logic [1:0]            o_akm_state,
    output logic [15:0]           o_akm_count,
    output logic [4:0]            o_akm_mask,
    output logic                  o_preauth,
    output logic                  o_caps_present
);

    logic        r_valid;
    logic [1:0]  r_kind, n_kind;
    logic [15:0] r_version, n_version;
    logic [1:0]  r_gstate, n_gstate;
    logic [7:0]  r_gcipher, n_gcipher;
    logic [1:0]  r_pstate, n_pstate;
    logic [15:0] r_pcount, n_pcount;
    logic [7:0]  r_pmask, n_pmask;
    logic [1:0]  r_astate, n_astate;
    logic [15:0] r_acount, n_acount;
    logic [4:0]  r_amask, n_amask;
    logic        r_preauth, n_preauth;
    logic        r_caps, n_caps;
    logic        parsed;
    logic [3:0]  st;

    always_comb begin
        st     = i_view.stage;
        parsed = (st >= wrsn_pkg::ST_GROUP) && (st <= wrsn_pkg::ST_DONE);

        if (i_view.elem_id == wrsn_pkg::ID_RSN) begin
            n_kind = parsed ? wrsn_pkg::KIND_RSN : wrsn_pkg::KIND_BAD;
        end else if (i_view.elem_id == wrsn_pkg::ID_VENDOR) begin
            n_kind = parsed ? wrsn_pkg::KIND_WPA : wrsn_pkg::KIND_BAD;
        end else begin
            n_kind = wrsn_pkg::KIND_OTHER;
        end

        n_version = '0;
        n_gstate  = wrsn_pkg::GRP_ABSENT;
        n_gcipher = '0;
        n_pstate  = wrsn_pkg::PW_NONE;
        n_pcount  = '0;
        n_pmask   = '0;
        n_astate  = wrsn_pkg::AKM_ABSENT;
        n_acount  = '0;
        n_amask   = '0;
        n_preauth = 1'b0;
        n_caps    = 1'b0;

        if (n_kind == wrsn_pkg::KIND_WPA || n_kind == wrsn_pkg::KIND_RSN) begin
            n_version = i_view.version;
            if (st < wrsn_pkg::ST_PCNT) begin
                n_gstate = wrsn_pkg::GRP_DEFAULT;
            end else if (i_view.grp_prop) begin
                n_gstate = wrsn_pkg::GRP_PROPR;
            end else begin
                n_gstate  = wrsn_pkg::GRP_STD;
                n_gcipher = i_view.grp_type;
            end

            if (st <= wrsn_pkg::ST_PCNT) begin
                n_pstate = wrsn_pkg::PW_DEFAULT;
            end else begin
                n_pcount = i_view.pw_count;
                if (st == wrsn_pkg::ST_PLIST) begin
                    n_pstate = wrsn_pkg::PW_TRUNC;
                end else begin
                    n_pstate = wrsn_pkg::PW_COMPLETE;
                    n_pmask  = i_view.pw_mask;
                end
            end

            if (st >= wrsn_pkg::ST_ALIST) begin
                n_acount = i_view.akm_count;
                if (st == wrsn_pkg::ST_ALIST) begin
                    n_astate = wrsn_pkg::AKM_TRUNC;
                end else begin
                    n_astate = wrsn_pkg::AKM_COMPLETE;
                    n_amask  = i_view.akm_mask;
                end
            end

            if (st == wrsn_pkg::ST_DONE) begin
                n_caps    = 1'b1;
                n_preauth = i_view.cap_bit0;
            end
        end
    end

    assign o_free = !r_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_kind    <= n_kind;
            r_version <= n_version;
            r_gstate  <= n_gstate;
            r_gcipher <= n_gcipher;
            r_pstate  <= n_pstate;
            r_pcount  <= n_pcount;
            r_pmask   <= n_pmask;
            r_astate  <= n_astate;
            r_acount  <= n_acount;
            r_amask   <= n_amask;
            r_preauth <= n_preauth;
            r_caps    <= n_caps;
        end
    end

    assign o_out_valid      = r_valid;
    assign o_element_kind   = r_kind;
    assign o_version        = r_version;
    assign o_group_state    = r_gstate;
    assign o_group_cipher   = r_gcipher;
    assign o_pairwise_state = r_pstate;
    assign o_pairwise_count = r_pcount;
    assign o_pairwise_mask  = r_pmask;
    assign o_akm_state      = r_astate;
    assign o_akm_count      = r_acount;
    assign o_akm_mask       = r_amask;
    assign o_preauth        = r_preauth;
    assign o_caps_present   = r_caps;

endmodule

// ===== src/wpa_rsn_element_parser.sv =====
// Top level of the WPA/RSN information element parser.
// Depends on wrsn_pkg, wrsn_parse and wrsn_out.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one element byte per
//   transaction, i_last_byte marking the final byte of the buffer.
//   Output channel (o_out_valid / i_out_ready) carries one summary per
//   buffer, produced for the transaction that has i_last_byte set.
//   Throughput: one byte per cycle unless a last byte is held (see below);
//   the parse state advances with an update of counters and compares per byte.
//   Latency: the summary is valid the cycle after the last byte is taken.
//   Reset (i_rst_n low, synchronous) returns the parser to the header
//   stage and empties the result register.
//   Receiver stall: the result register holds the summary. Bytes that are
//   not last keep flowing; a last byte waits (o_in_ready low) only while
//   the result register is full and not being taken that cycle.
//   After each summary the parser restarts for the next element.
module wpa_rsn_element_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_element_byte,
    input  logic        i_last_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_element_kind,
    output logic [15:0] o_version,
    output logic [1:0]  o_group_state,
    output logic [7:0]  o_group_cipher,
    output logic [1:0]  o_pairwise_state,
    output logic [15:0] o_pairwise_count,
    output logic [7:0]  o_pairwise_mask,
    output logic [1:0]  o_akm_state,
    output logic [15:0] o_akm_count,
    output logic [4:0]  o_akm_mask,
    output logic        o_preauth,
    output logic        o_caps_present
);

    wrsn_pkg::t_parse_view view;
    logic                  out_free;
    logic                  accept;
    logic                  load;

    assign o_in_ready = out_free || !i_last_byte;
    assign accept     = i_in_valid && o_in_ready;
    assign load       = accept && i_last_byte;

    wrsn_parse u_parse (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_element_byte (i_element_byte),
        .i_last_byte    (i_last_byte),
        .o_view         (view)
    );

    wrsn_out u_out (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_load           (load),
        .i_view           (view),
        .i_out_ready      (i_out_ready),
        .o_free           (out_free),
        .o_out_valid      (o_out_valid),
        .o_element_kind   (o_element_kind),
        .o_version        (o_version),
        .o_group_state    (o_group_state),
        .o_group_cipher   (o_group_cipher),
        .o_pairwise_state (o_pairwise_state),
        .o_pairwise_count (o_pairwise_count),
        .o_pairwise_mask  (o_pairwise_mask),
        .o_akm_state      (o_akm_state),
        .o_akm_count      (o_akm_count),
        .o_akm_mask       (o_akm_mask),
        .o_preauth        (o_preauth),
        .o_caps_present   (o_caps_present)
    );

endmodule
